### rtl/utf8d_pkg.sv
// ============================================================================
// UTF-8 decoder package
// Shared types, lead byte constants and decode functions for the decoder.
// ============================================================================
package utf8d_pkg;

  // Default depth of the job queue between the front and the back.
  localparam int unsigned JobQueueDepth = 2;

  localparam logic [7:0]  AsciiLimit  = 8'h80;
  localparam logic [2:0]  Lead2Tag    = 3'h6;
  localparam logic [3:0]  Lead3Tag    = 4'hE;
  localparam logic [4:0]  Lead4Tag    = 5'h1E;
  localparam logic [7:0]  Lead2Mask   = 8'h1F;
  localparam logic [7:0]  ContMask    = 8'h3F;
  localparam logic [7:0]  Lead3Mask   = 8'h0F;
  localparam logic [7:0]  Lead4Mask   = 8'h07;
  localparam logic [20:0] Replacement = 21'h00FFFD;

  // One decode job: the bytes of a closed sequence and how many are valid.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  used;
    logic        sub;
  } dec_t;

  typedef struct packed {
    logic        done;
    logic        eor;
    logic        sub;
    logic [2:0]  used;
    logic [20:0] cp;
  } res_t;

  // Sequence length implied by a lead byte, zero for an invalid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    if (c < AsciiLimit) begin
      len = 3'd1;
    end else if (c[7:5] == Lead2Tag) begin
      len = 3'd2;
    end else if (c[7:4] == Lead3Tag) begin
      len = 3'd3;
    end else if (c[7:3] == Lead4Tag) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Decodes at the lowest byte of b with avail bytes left in the string.
  function automatic dec_t decode(input logic [31:0] b, input logic [2:0] avail);
    dec_t       r;
    logic [2:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    b0  = b[7:0];
    b1  = b[15:8] & ContMask;
    b2  = b[23:16] & ContMask;
    b3  = b[31:24] & ContMask;
    len = lead_len(b0);
    r.cp   = Replacement;
    r.used = 3'd1;
    r.sub  = 1'b1;
    if (!(len == 3'd0 || (len > 3'd1 && avail < len))) begin
      r.used = len;
      r.sub  = 1'b0;
      case (len)
        3'd1: r.cp = {13'd0, b0};
        3'd2: r.cp = (21'(b0 & Lead2Mask) << 6) | 21'(b1);
        3'd3: r.cp = (21'(b0 & Lead3Mask) << 12) | (21'(b1) << 6) | 21'(b2);
        default: r.cp = (21'(b0 & Lead4Mask) << 18) | (21'(b1) << 12)
                        | (21'(b2) << 6) | 21'(b3);
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/utf8d_front.sv
// ============================================================================
// UTF-8 decoder front
// Accepts string bytes, holds an open sequence and issues decode jobs.
// ============================================================================
module utf8d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output utf8d_pkg::job_t  job_o
);
  import utf8d_pkg::*;

  logic [7:0]      held_q [3];
  logic [1:0]      cnt_q, cnt_d;
  logic [3:0][7:0] buf_w;
  logic [2:0]      n;
  logic [2:0]      len;
  logic            hold;
  logic            accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    buf_w = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt_q) begin
        buf_w[i] = held_q[i];
      end
    end
    buf_w[cnt_q] = in_byte_i;
  end

  assign n    = {1'b0, cnt_q} + 3'd1;
  assign len  = lead_len(buf_w[0]);
  // The sequence stays open until its last byte or the end of the string.
  assign hold = !in_last_i && (len != 3'd0) && (n < len);

  assign push_o      = accept && !hold;
  assign job_o.bytes = buf_w;
  assign job_o.n     = n;
  assign job_o.last  = in_last_i;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = hold ? n[1:0] : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold) begin
      held_q[cnt_q] <= in_byte_i;
    end
  end

endmodule

### rtl/utf8d_job_fifo.sv
// ============================================================================
// UTF-8 decoder job queue
// Short register queue that lets the front and the back stall independently.
// ============================================================================
module utf8d_job_fifo #(
  parameter int unsigned Depth = utf8d_pkg::JobQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8d_pkg::job_t  data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output utf8d_pkg::job_t  data_o
);
  import utf8d_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/utf8d_back.sv
// ============================================================================
// UTF-8 decoder back
// Decodes queued jobs into code points, one result per cycle unless stalled.
// ============================================================================
module utf8d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  utf8d_pkg::job_t  job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output utf8d_pkg::res_t  out_o
);
  import utf8d_pkg::*;

  logic [1:0]  pos_q, pos_d;
  logic [1:0]  k_q, k_d;
  logic        ov_q, ov_d;
  res_t        od_q, od_d;
  logic [31:0] shifted;
  logic [2:0]  avail;
  logic [2:0]  end_pos;
  dec_t        dec;
  logic        fin;
  logic        produce;

  assign shifted = job_i.bytes >> {pos_q, 3'b000};
  assign avail   = job_i.n - {1'b0, pos_q};
  assign dec     = decode(shifted, avail);
  assign end_pos = {1'b0, pos_q} + dec.used;
  // A job ending the string is re-decoded from its next unused byte until done.
  assign fin     = !job_i.last || (end_pos >= job_i.n) || (k_q == 2'd2);
  assign produce = job_valid_i && (!ov_q || out_ready_i);
  assign pop_o   = produce && fin;

  always_comb begin
    pos_d = pos_q;
    k_d   = k_q;
    ov_d  = ov_q;
    od_d  = od_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    if (produce) begin
      ov_d      = 1'b1;
      od_d.cp   = dec.cp;
      od_d.used = dec.used;
      od_d.sub  = dec.sub;
      od_d.eor  = fin;
      od_d.done = fin && job_i.last;
      pos_d     = fin ? 2'd0 : end_pos[1:0];
      k_d       = fin ? 2'd0 : k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      k_q   <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      k_q   <= k_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = od_q;

endmodule

### rtl/utf8_code_point_decoder.sv
// ============================================================================
// UTF-8 code point decoder
// Turns a byte stream into Unicode code points, one byte per cycle when not stalled.
// ============================================================================
// The slave stream carries one string byte per transfer in tdata, with tlast
// on the final byte of the string. The master stream carries one code point
// per transfer; tlast marks the final code point of the string.
// A byte is taken every cycle while the job queue has room. A byte that
// closes a sequence (or is an invalid lead) yields its code point on the
// master side through the job queue and the output register; bytes inside
// a sequence yield nothing. A string that ends inside a sequence yields up
// to three results from the final byte, which the back end produces one
// result per cycle while the receiver takes them; meanwhile the queue fills
// and tready may drop. Steady throughput is one byte per cycle while the
// job queue has room. Reset clears the open sequence and empties the queue
// and output register; no clearing pass is needed. When the receiver stalls,
// the output register holds its result, the queue absorbs up to QueueDepth
// more jobs, and then tready goes low until the receiver takes results again.
// ============================================================================
module utf8_code_point_decoder #(
  parameter int unsigned QueueDepth = utf8d_pkg::JobQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [20:0] code_point, [23:21] bytes_used,
                                      // [24] end_of_run, [31:25] zero
  output logic        m_axis_tuser,   // [0] substituted
  output logic        m_axis_tlast    // string_done
);
  import utf8d_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic job_valid;
  job_t job_in;
  job_t job_out;
  res_t res;

  utf8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  utf8d_job_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .data_o  (job_out)
  );

  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {7'd0, res.eor, res.used, res.cp};
  assign m_axis_tuser = res.sub;
  assign m_axis_tlast = res.done;

  // A substituted result is always the replacement character for one byte.
  a_sub_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[20:0] == Replacement && m_axis_tdata[23:21] == 3'd1))
    else $error("substituted result with wrong value");

  // The final byte of a string always issues a decode job.
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> job_valid)
    else $error("final byte did not issue a job");

  // The last result of a string also ends the run of its byte.
  a_done_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[24])
    else $error("string end without end of run");

endmodule

### test/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 decoder checker
// Watches the byte and code point streams of the decoder, predicts the code
// points of every accepted byte and compares each result transfer with the
// oldest prediction, field by field.
// ============================================================================
module utf8_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  input  logic        out_user_i,
  input  logic        out_last_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          substitutions_o
);

  localparam logic [20:0] CpReplacement = 21'h00FFFD;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  used;
    logic        sub;
    logic        eor;
    logic        done;
  } code_point_t;

  code_point_t    expected_cp_q[$];
  logic [7:0]     open_bytes[3];
  int unsigned    open_count;

  initial begin
    errors_o        = 0;
    pending_o       = 0;
    results_o       = 0;
    substitutions_o = 0;
    open_count      = 0;
  end

  function automatic int unsigned seq_length(input logic [7:0] lead);
    int unsigned len;
    casez (lead)
      8'b0???????: len = 1;
      8'b110?????: len = 2;
      8'b1110????: len = 3;
      8'b11110???: len = 4;
      default:     len = 0;
    endcase
    return len;
  endfunction

  // Decodes at b0 with avail bytes left before the end of what is known.
  function automatic code_point_t decode_at(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input int unsigned avail);
    code_point_t r;
    int unsigned len;
    len    = seq_length(b0);
    r      = '0;
    r.cp   = CpReplacement;
    r.used = 3'd1;
    r.sub  = 1'b1;
    if (len != 0 && !(len > 1 && avail < len)) begin
      r.used = 3'(len);
      r.sub  = 1'b0;
      case (len)
        1:       r.cp = {13'd0, b0};
        2:       r.cp = {10'd0, b0[4:0], b1[5:0]};
        3:       r.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        default: r.cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      endcase
    end
    return r;
  endfunction

  task automatic predict_code_points(input logic [7:0] b, input logic last);
    logic [7:0]  seq[7];
    code_point_t res[3];
    code_point_t r;
    int unsigned n;
    int unsigned p;
    int unsigned k;
    int unsigned len;
    int unsigned i;
    for (i = 0; i < 7; i++) seq[i] = 8'h00;
    for (i = 0; i < open_count; i++) seq[i] = open_bytes[i];
    seq[open_count] = b;
    n = open_count + 1;
    if (!last) begin
      len = seq_length(seq[0]);
      if (len == 0 || n >= len) begin
        r = decode_at(seq[0], seq[1], seq[2], seq[3], n);
        r.eor = 1'b1;
        expected_cp_q.push_back(r);
        open_count = 0;
      end else begin
        open_bytes[n - 1] = b;
        open_count = n;
      end
    end else begin
      // The string ends here: whatever is held is decoded again from its start,
      // with truncated leads turning into substitutions.
      p = 0;
      k = 0;
      while (p < n && k < 3) begin
        res[k] = decode_at(seq[p], seq[p + 1], seq[p + 2], seq[p + 3], n - p);
        p += res[k].used;
        k++;
      end
      res[k - 1].eor  = 1'b1;
      res[k - 1].done = 1'b1;
      for (i = 0; i < k; i++) expected_cp_q.push_back(res[i]);
      open_count = 0;
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
      errors_o++;
    end
  endtask

  task automatic check_code_point();
    code_point_t e;
    if (expected_cp_q.size() == 0) begin
      $error("code point transfer with nothing expected: tdata 0x%0h", out_data_i);
      errors_o++;
    end else begin
      e = expected_cp_q.pop_front();
      compare_field("code_point", 32'(e.cp), 32'(out_data_i[20:0]));
      compare_field("bytes_used", 32'(e.used), 32'(out_data_i[23:21]));
      compare_field("end_of_run", 32'(e.eor), 32'(out_data_i[24]));
      compare_field("tdata padding", 32'd0, 32'(out_data_i[31:25]));
      compare_field("substituted", 32'(e.sub), 32'(out_user_i));
      compare_field("string_done", 32'(e.done), 32'(out_last_i));
      results_o++;
      if (e.sub) substitutions_o++;
    end
  endtask

  // Bytes are predicted before results are checked, so a result caused by a
  // byte taken on the same edge would still find its prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_count = 0;
      expected_cp_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_code_points(in_byte_i, in_last_i);
      if (out_valid_i && out_ready_i) check_code_point();
    end
    pending_o = expected_cp_q.size();
  end

endmodule

### test/tb_utf8_code_point_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 code point decoder testbench
// Sends directed and random strings (well-formed, truncated at the end and
// noisy) through the decoder with random idling on both streams, and lets a
// checker module verify every code point transfer.
// ============================================================================
module tb_utf8_code_point_decoder;

  localparam int unsigned ByteTarget  = 280;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DirectedLen = 24;

  // {end_of_string, data_byte}: extremes of each lead length, invalid leads,
  // a clean end on a four-byte sequence and strings cut inside a sequence.
  localparam logic [8:0] DirectedBytes[DirectedLen] = '{
    9'h000, 9'h07F,
    9'h0DF, 9'h0BF,
    9'h0E0, 9'h080, 9'h080,
    9'h0EF, 9'h0BF, 9'h0BF,
    9'h0F7, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h080, 9'h0FF,
    9'h0F0, 9'h09F, 9'h098, 9'h180,
    9'h0F0, 9'h041, 9'h1E2,
    9'h1C3
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int          errors;
  int          pending;
  int          results;
  int          substitutions;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned drains;
  int unsigned cycles;
  bit          idle_en;
  bit          hold_req;

  utf8_code_point_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  utf8_decode_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_byte_i       (s_axis_tdata),
    .in_last_i       (s_axis_tlast),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_user_i      (m_axis_tuser),
    .out_last_i      (m_axis_tlast),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results),
    .substitutions_o (substitutions)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d code points still expected", cycles, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Code point receiver: random stall bursts, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned len);
    logic [7:0] b;
    case (len)
      1:       b = {1'b0, 7'($urandom)};
      2:       b = {3'b110, 5'($urandom)};
      3:       b = {4'b1110, 4'($urandom)};
      default: b = {5'b11110, 3'($urandom)};
    endcase
    return b;
  endfunction

  // Bytes after a lead are only masked, so a few are left fully random.
  function automatic logic [7:0] follow_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) b = 8'($urandom);
    else b = {2'b10, 6'($urandom)};
    return b;
  endfunction

  task automatic send_string(input int unsigned n_chars, input bit truncate,
                             input bit noisy);
    logic [7:0]  str[$];
    int unsigned c;
    int unsigned len;
    int unsigned keep;
    int unsigned i;
    for (c = 0; c < n_chars; c++) begin
      len = $urandom_range(1, 4);
      if (truncate && c == n_chars - 1) len = $urandom_range(2, 4);
      if (noisy && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) str.push_back({2'b10, 6'($urandom)});
        else str.push_back({5'b11111, 3'($urandom)});
      end else begin
        keep = len;
        if (truncate && c == n_chars - 1) keep = $urandom_range(1, len - 1);
        str.push_back(lead_byte(len));
        for (i = 1; i < keep; i++) str.push_back(follow_byte());
      end
    end
    for (i = 0; i < str.size(); i++) send_byte(str[i], i == str.size() - 1);
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Lets the decoder drain completely before the stream resumes. The wait
  // starts at a falling edge, after the checker has predicted the last byte.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    drains++;
  endtask

  initial begin
    int unsigned i;
    int unsigned next_drain;
    bit          hold_done;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    strings_sent  = 0;
    drains        = 0;
    next_drain    = 60;
    hold_done     = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DirectedLen; i++) begin
      send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
    end
    drain_results();

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= next_drain) begin
        drain_results();
        next_drain += 120;
      end
      if (!hold_done && bytes_sent >= 110) begin
        // Back-to-back bytes against a stalled receiver fill the job queue.
        hold_done = 1'b1;
        hold_req  = 1'b1;
        idle_en   = 1'b0;
        send_string(8, 1'b0, 1'b0);
        idle_en   = 1'b1;
      end
      if (bytes_sent + 40 >= ByteTarget) idle_en = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_string($urandom_range(1, 4), 1'b0, 1'b0);
        5, 6:          send_string($urandom_range(1, 3), 1'b1, 1'b0);
        7, 8:          send_string($urandom_range(1, 4), 1'($urandom_range(0, 1)), 1'b1);
        default:       send_noise();
      endcase
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d code points, %0d substituted.",
             bytes_sent, strings_sent, results, substitutions);
    $display("Receiver held off %0d cycles once; sender waited for a full drain %0d times.",
             HoldCycles, drains);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_job_fifo.sv
rtl/utf8d_back.sv
rtl/utf8_code_point_decoder.sv
test/utf8_decode_checker.sv
test/tb_utf8_code_point_decoder.sv
